/* design/smts_pkg.sv */
// ----------------------------------------------------------------------------
// smts_pkg
// Shared types and constants for the twin stack: action and status codes,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smts_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 9;
    localparam int ACT_W  = 2;
    localparam int STS_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_ONE = 2'd0,
        ACT_PUSH_TWO = 2'd1,
        ACT_POP_ONE  = 2'd2,
        ACT_POP_TWO  = 2'd3
    } t_action;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status_code;

    // controller -> datapath
    typedef struct packed {
        logic take;     // accept the item on the input channel
        logic load_rd;  // load the output register from the RAM read data
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty_one;
        logic empty_two;
        logic out_busy; // result held and not taken this cycle
    } t_sts;

endpackage

`default_nettype wire

/* design/smts_ram.sv */
// ----------------------------------------------------------------------------
// smts_ram
// Generic single-port RAM with one shared address, write enable and a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/smts_ctrl.sv */
// ----------------------------------------------------------------------------
// smts_ctrl
// Controller: admits items on the input channel and, for a pop that reaches a
// stored word, waits in S_READ on the registered RAM read.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire smts_pkg::t_action      i_action,
    input  wire smts_pkg::t_sts         i_sts,
    output logic                        o_in_ready,
    output smts_pkg::t_cmd              o_cmd
);
    import smts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;
    logic   needs_read;

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.out_busy;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        case (i_action)
            ACT_POP_ONE: needs_read = !i_sts.empty_one;
            ACT_POP_TWO: needs_read = !i_sts.empty_two;
            default:     needs_read = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && needs_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.take    = take;
    assign o_cmd.load_rd = (r_state == S_READ);

endmodule

`default_nettype wire

/* design/smts_dpath.sv */
// ----------------------------------------------------------------------------
// smts_dpath
// Datapath: capacity register, the two stack counts, the shared word RAM and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_dpath #(
    parameter int DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [smts_pkg::CAP_W-1:0]    i_cfg_wr_data,
    input  wire smts_pkg::t_action             i_action,
    input  wire logic [smts_pkg::WORD_W-1:0]   i_push_value,
    input  wire smts_pkg::t_cmd                i_cmd,
    output smts_pkg::t_sts                     o_sts,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [smts_pkg::WORD_W-1:0]        o_pop_value,
    output logic [smts_pkg::STS_W-1:0]         o_status
);
    import smts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [16:0] DEPTH_X = 17'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_EFF_RESET =
        (17'(CAP_RESET) > DEPTH_X) ? CAP_W'(DEPTH) : CAP_RESET;

    logic [CAP_W-1:0]  r_cap;       // effective capacity, already limited to DEPTH
    logic [CAP_W-1:0]  n_cap;
    logic [CAP_W-1:0]  r_count_one;
    logic [CAP_W-1:0]  n_count_one;
    logic [CAP_W-1:0]  r_count_two;
    logic [CAP_W-1:0]  n_count_two;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_pop_value;
    logic [STS_W-1:0]  r_status;

    logic [CAP_W:0]    used;
    logic              full;
    logic              ram_we;
    logic              ram_re;
    logic [CAP_W-1:0]  ram_addr;
    logic [WORD_W-1:0] ram_rdata;
    logic              imm_load;
    logic [WORD_W-1:0] imm_value;
    t_status_code      imm_status;

    assign used = {1'b0, r_count_one} + {1'b0, r_count_two};
    assign full = used >= {1'b0, r_cap};

    assign o_sts.empty_one = (r_count_one == '0);
    assign o_sts.empty_two = (r_count_two == '0);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    always_comb begin
        n_cap       = r_cap;
        n_count_one = r_count_one;
        n_count_two = r_count_two;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_count_one;
        imm_load    = 1'b0;
        imm_value   = '0;
        imm_status  = ST_OK;
        if (i_cfg_wr_en) begin
            // clamp to the physical depth and empty both stacks
            n_cap       = ({8'd0, i_cfg_wr_data} > DEPTH_X) ? CAP_W'(DEPTH) : i_cfg_wr_data;
            n_count_one = '0;
            n_count_two = '0;
        end else if (i_cmd.take) begin
            case (i_action)
                ACT_PUSH_ONE: begin
                    imm_load = 1'b1;
                    if (full) begin
                        imm_status = ST_OVERFLOW;
                    end else begin
                        ram_we      = 1'b1;
                        ram_addr    = r_count_one;
                        n_count_one = r_count_one + 1'b1;
                    end
                end
                ACT_PUSH_TWO: begin
                    imm_load = 1'b1;
                    if (full) begin
                        imm_status = ST_OVERFLOW;
                    end else begin
                        ram_we      = 1'b1;
                        ram_addr    = r_cap - r_count_two - 1'b1;
                        n_count_two = r_count_two + 1'b1;
                    end
                end
                ACT_POP_ONE: begin
                    if (r_count_one == '0) begin
                        imm_load   = 1'b1;
                        imm_value  = '1;
                        imm_status = ST_UNDERFLOW;
                    end else begin
                        ram_re      = 1'b1;
                        ram_addr    = r_count_one - 1'b1;
                        n_count_one = r_count_one - 1'b1;
                    end
                end
                ACT_POP_TWO: begin
                    if (r_count_two == '0) begin
                        imm_load   = 1'b1;
                        imm_value  = '1;
                        imm_status = ST_UNDERFLOW;
                    end else begin
                        ram_re      = 1'b1;
                        ram_addr    = r_cap - r_count_two;
                        n_count_two = r_count_two - 1'b1;
                    end
                end
                default: begin
                    imm_load = 1'b0;
                end
            endcase
        end
    end

    smts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (AW'(ram_addr)),
        .i_wdata (i_push_value),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_EFF_RESET;
            r_count_one <= '0;
            r_count_two <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap       <= n_cap;
            r_count_one <= n_count_one;
            r_count_two <= n_count_two;
            if (imm_load || i_cmd.load_rd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (imm_load) begin
            r_pop_value <= imm_value;
            r_status    <= imm_status;
        end else if (i_cmd.load_rd) begin
            r_pop_value <= ram_rdata;
            r_status    <= ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

endmodule

`default_nettype wire

/* design/shared_memory_twin_stack.sv */
// ----------------------------------------------------------------------------
// shared_memory_twin_stack
// Two stacks sharing one word RAM: stack one grows up from address 0, stack
// two grows down from the configured capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one action and a push
//   word; each accepted item gives exactly one result on the output channel
//   (o_out_valid / i_out_ready) with the popped word and a status.
//   Pushes and pops of an empty stack produce their result in the cycle after
//   acceptance and allow one item per cycle while the receiver keeps up. A pop
//   that reaches a stored word waits on the registered RAM read, then loads
//   the output register; no new item is taken until that pop is through.
//   A result waiting in the output register does not block the next item as
//   long as the receiver takes it in the same cycle; while the receiver
//   stalls the result holds and o_in_ready stays low.
//   The capacity register (i_cfg_wr_en / i_cfg_wr_data) is limited to
//   DEPTH, and a write to it empties both stacks.
//   Reset empties both stacks and sets the capacity to 256 (limited to DEPTH);
//   RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_memory_twin_stack #(
    parameter int DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [smts_pkg::CAP_W-1:0]    i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [smts_pkg::ACT_W-1:0]    i_action,
    input  wire logic signed [smts_pkg::WORD_W-1:0] i_push_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [smts_pkg::WORD_W-1:0] o_pop_value,
    output logic [smts_pkg::STS_W-1:0]         o_status
);
    import smts_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    t_action           action;
    logic [WORD_W-1:0] pop_value;

    assign action      = t_action'(i_action);
    assign o_pop_value = pop_value;

    smts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (action),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    smts_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_action      (action),
        .i_push_value  (i_push_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pop_value   (pop_value),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

/* design/smts_chk.sv */
// ----------------------------------------------------------------------------
// smts_chk
// Port-level checks for the twin stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smts_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic [smts_pkg::ACT_W-1:0]    i_action,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [smts_pkg::WORD_W-1:0]   o_pop_value,
    input wire logic [smts_pkg::STS_W-1:0]    o_status
);
    import smts_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pop_value)
            && $stable(o_status))
        else $error("result changed while stalled");

    // a push answers in the next cycle with a zero word and no underflow
    a_push_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_action[1] |=>
            o_out_valid && (o_pop_value == '0) && (o_status != ST_UNDERFLOW))
        else $error("push result missing or malformed");

    // underflow always returns all ones
    a_underflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_UNDERFLOW) |-> (o_pop_value == '1))
        else $error("underflow word is not -1");

    // refused push returns zero, status code stays in range
    a_overflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3)
            && ((o_status != ST_OVERFLOW) || (o_pop_value == '0)))
        else $error("bad status or overflow word");

endmodule

bind shared_memory_twin_stack smts_chk u_smts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pop_value (o_pop_value),
    .o_status    (o_status)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the twin stack. Actions and capacity writes queue up
// front and feed a falling-edge driver; a rising-edge monitor predicts each
// accepted item and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;
    import smts_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CAP,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind                 kind;
        t_action                  act;
        logic [WORD_W-1:0]        word;
        logic [CAP_W-1:0]         cap;
    } t_op;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        t_status_code             status;
    } t_reply;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]         i_cfg_wr_data = '0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_ready;
    logic [ACT_W-1:0]         i_action      = ACT_PUSH_ONE;
    logic signed [WORD_W-1:0] i_push_value  = '0;
    logic                     o_out_valid;
    logic                     i_out_ready   = 1'b0;
    logic signed [WORD_W-1:0] o_pop_value;
    logic [STS_W-1:0]         o_status;

    shared_memory_twin_stack #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                depth_one = 0;
    int                depth_two = 0;
    logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

    t_op    op_q[$];
    t_reply stack_replies[$];
    logic   item_taken    = 1'b0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     errors        = 0;
    int     cycles        = 0;

    function automatic t_reply twin_stack_step(t_action act, logic [WORD_W-1:0] word);
        t_reply r;
        int     lim;
        logic   full;
        lim      = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
        full     = (depth_one + depth_two) >= lim;
        r.value  = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH_ONE: begin
                if (full) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_words[depth_one] = word;
                    depth_one++;
                end
            end
            ACT_PUSH_TWO: begin
                if (full) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    depth_two++;
                    shadow_words[lim - depth_two] = word;
                end
            end
            ACT_POP_ONE: begin
                if (depth_one == 0) begin
                    r.value  = '1;
                    r.status = ST_UNDERFLOW;
                end else begin
                    depth_one--;
                    r.value = shadow_words[depth_one];
                end
            end
            default: begin
                if (depth_two == 0) begin
                    r.value  = '1;
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.value = shadow_words[lim - depth_two];
                    depth_two--;
                end
            end
        endcase
        return r;
    endfunction

    // driver: launch items and capacity writes at the falling edge
    always @(negedge i_clk) begin
        logic nxt_valid;
        logic nxt_cfg_en;
        t_op  head;
        nxt_valid  = i_in_valid && !item_taken;
        nxt_cfg_en = 1'b0;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && !nxt_valid && op_q.size() != 0) begin
            head = op_q[0];
            case (head.kind)
                OP_ITEM: begin
                    if ($urandom_range(99) >= send_idle_pct) begin
                        nxt_valid = 1'b1;
                        i_action     <= head.act;
                        i_push_value <= head.word;
                        void'(op_q.pop_front());
                    end
                end
                OP_CAP: begin
                    // write only once every result is home
                    if (stack_replies.size() == 0) begin
                        nxt_cfg_en = 1'b1;
                        i_cfg_wr_data <= head.cap;
                        void'(op_q.pop_front());
                    end
                end
                default: begin
                    if (stack_replies.size() == 0) begin
                        void'(op_q.pop_front());
                    end
                end
            endcase
        end
        i_in_valid  <= nxt_valid;
        i_cfg_wr_en <= nxt_cfg_en;
    end

    // monitor: check results, then predict the item taken at this edge
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            item_taken = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (stack_replies.size() == 0) begin
                    $display("%0t: unexpected result pop_value %0d status %0d",
                             $time, o_pop_value, o_status);
                    errors++;
                end else begin
                    want = stack_replies.pop_front();
                    if (o_pop_value !== want.value) begin
                        $display("%0t: pop_value mismatch expected %0d actual %0d",
                                 $time, want.value, o_pop_value);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, o_status);
                        errors++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                shadow_cap = i_cfg_wr_data;
                depth_one  = 0;
                depth_two  = 0;
            end
            item_taken = i_in_valid && o_in_ready;
            if (item_taken) begin
                stack_replies.push_back(twin_stack_step(t_action'(i_action), i_push_value));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** shared_memory_twin_stack: FAILED **");
            $finish;
        end
    end

    task automatic queue_item(t_action act, logic [WORD_W-1:0] word);
        op_q.push_back('{kind: OP_ITEM, act: act, word: word, cap: '0});
    endtask

    task automatic queue_capacity(logic [CAP_W-1:0] cap);
        op_q.push_back('{kind: OP_CAP, act: ACT_PUSH_ONE, word: '0, cap: cap});
    endtask

    task automatic queue_drain();
        op_q.push_back('{kind: OP_DRAIN, act: ACT_PUSH_ONE, word: '0, cap: '0});
    endtask

    // random actions on random stacks, push_pct of them pushes
    task automatic queue_mix(int n, int push_pct);
        logic two;
        for (int k = 0; k < n; k++) begin
            two = 1'($urandom_range(1));
            if ($urandom_range(99) < push_pct) begin
                queue_item(two ? ACT_PUSH_TWO : ACT_PUSH_ONE, $urandom);
            end else begin
                queue_item(two ? ACT_POP_TWO : ACT_POP_ONE, $urandom);
            end
        end
    endtask

    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
        end while (op_q.size() != 0 || i_in_valid || stack_replies.size() != 0);
    endtask

    task automatic run_phase(int s_idle, int r_idle, int n_items);
        int queued;
        int cap;
        int lim;
        int len;
        wait_quiet();
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        queued = 0;
        while (queued < n_items) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: cap = $urandom_range(1, 8);
                5, 6:          cap = $urandom_range(9, 40);
                7:             cap = 256;
                8:             cap = $urandom_range(257, 511);
                default:       cap = 0;
            endcase
            lim = (cap > 40) ? 40 : cap;
            len = $urandom_range(4, lim + 8);
            queue_capacity(CAP_W'(cap));
            // fill, churn, then empty out
            queue_mix(len, 80);
            if (queued == 0) begin
                queue_drain();
            end
            queue_mix(len, 50);
            queue_mix(len, 20);
            queued += 3 * len;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty stacks at reset capacity, extreme words, LIFO order
        queue_item(ACT_POP_ONE, 32'h0000_0000);
        queue_item(ACT_POP_TWO, 32'hFFFF_FFFF);
        queue_item(ACT_PUSH_ONE, 32'h7FFF_FFFF);
        queue_item(ACT_PUSH_ONE, 32'h8000_0000);
        queue_item(ACT_PUSH_TWO, 32'h0000_0000);
        queue_item(ACT_PUSH_TWO, 32'hFFFF_FFFF);
        queue_item(ACT_POP_TWO, 32'h0000_0000);
        queue_item(ACT_POP_ONE, 32'h0000_0000);
        queue_item(ACT_POP_TWO, 32'h0000_0000);
        queue_item(ACT_POP_ONE, 32'h0000_0000);
        // single word shared: second push refused
        queue_capacity(9'd1);
        queue_item(ACT_PUSH_TWO, 32'h1234_5678);
        queue_item(ACT_PUSH_ONE, 32'h0BAD_F00D);
        queue_item(ACT_POP_ONE, 32'h0000_0000);
        queue_item(ACT_POP_TWO, 32'h0000_0000);
        // zero capacity: refuse everything
        queue_capacity(9'd0);
        queue_item(ACT_PUSH_ONE, 32'h5555_5555);
        queue_item(ACT_PUSH_TWO, 32'hAAAA_AAAA);
        queue_item(ACT_POP_ONE, 32'h0000_0000);
        queue_item(ACT_POP_TWO, 32'h0000_0000);
        // stacks meet in the middle
        queue_capacity(9'd2);
        queue_item(ACT_PUSH_ONE, 32'h5555_5555);
        queue_item(ACT_PUSH_TWO, 32'hAAAA_AAAA);
        queue_item(ACT_PUSH_TWO, 32'hFFFF_0000);
        queue_item(ACT_POP_ONE, 32'h0000_0000);
        queue_item(ACT_POP_TWO, 32'h0000_0000);
        // above DEPTH: saturate
        queue_capacity(9'd511);
        queue_item(ACT_PUSH_TWO, 32'hDEAD_BEEF);
        queue_item(ACT_POP_TWO, 32'h0000_0000);

        // fill the whole memory past full, then pop past empty
        queue_capacity(9'd256);
        queue_mix(270, 100);
        queue_drain();
        queue_mix(270, 0);

        run_phase(0, 0, 120);
        run_phase(63, 0, 120);
        run_phase(0, 63, 120);
        run_phase(31, 31, 120);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("** shared_memory_twin_stack: PASSED **");
        end else begin
            $display("** shared_memory_twin_stack: FAILED **");
        end
        $finish;
    end

endmodule
